// ===== rtl/core/gbvp_pkg.sv =====
// Shared types and constants of the geometry blob varint parser.
`default_nettype none
package gbvp_pkg;

   localparam int VarintMaxBytes = 10;
   localparam int QueueDepth     = 4;
   localparam int PtrW           = $clog2(QueueDepth);
   localparam int CntW           = $clog2(QueueDepth + 1);
   localparam int RecPerGrp      = 3;

   localparam logic [63:0] I64_MAX = 64'h7fff_ffff_ffff_ffff;

   // Record codes
   localparam logic [2:0] REC_HEADER = 3'd0;
   localparam logic [2:0] REC_PART   = 3'd1;
   localparam logic [2:0] REC_XY     = 3'd2;
   localparam logic [2:0] REC_Z      = 3'd3;
   localparam logic [2:0] REC_M      = 3'd4;
   localparam logic [2:0] REC_END    = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_CURVE    = 3'd4;
   localparam logic [2:0] ST_TYPE     = 3'd5;

   // Geometry kinds
   localparam logic [2:0] KIND_POINT   = 3'd0;
   localparam logic [2:0] KIND_MPOINT  = 3'd1;
   localparam logic [2:0] KIND_MLINE   = 3'd2;
   localparam logic [2:0] KIND_MPOLY   = 3'd3;
   localparam logic [2:0] KIND_UNSUPP  = 3'd4;

   // Configuration register indexes
   localparam logic CSR_LAYER_Z = 1'b0;
   localparam logic CSR_LAYER_M = 1'b1;

   typedef struct packed {
      logic [2:0]  record;
      logic [63:0] value_a;
      logic [63:0] value_b;
      logic [2:0]  kind;
      logic        z;
      logic        m;
      logic [2:0]  status;
      logic        last;
   } rec_type;

   typedef struct packed {
      rec_type [RecPerGrp-1:0] recs;
      logic [1:0]              count;
   } grp_type;

endpackage
`default_nettype wire

// ===== rtl/core/gbvp_front.sv =====
// Front part: varint assembly, blob parsing and record group building.
`default_nettype none
module gbvp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        byte_in,
   input  wire logic              end_of_blob,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic              csr_wdata,
   output logic                   grp_valid,
   output gbvp_pkg::grp_type      grp
);
   import gbvp_pkg::*;

   typedef enum logic [3:0] {
      PH_TYPE, PH_PT_X, PH_PT_Y, PH_PT_Z, PH_PT_M, PH_NPOINTS, PH_NPARTS,
      PH_NCURVES, PH_BBOX, PH_PARTS, PH_X, PH_Y, PH_Z, PH_M
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  shift_ff, shift_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [5:0]  kzmc_ff, kzmc_in;
   logic [31:0] pt_ff, pt_in;
   logic [31:0] parts_ff, parts_in;
   logic [31:0] psum_ff, psum_in;
   logic [31:0] pleft_ff, pleft_in;
   logic [1:0]  bbox_ff, bbox_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] px_ff, px_in;
   logic [63:0] ord_ff, ord_in;
   logic        fin_ff, fin_in;
   logic [2:0]  held_ff, held_in;
   logic        bad_ff, bad_in;
   logic        lz_ff, lz_in;
   logic        lm_ff, lm_in;

   // Varint datapath
   logic        sgn, first, more, hi_bad, too_long;
   logic [63:0] u_base, u_val, s_mag, s_val;
   logic [6:0]  u_sh;
   logic        s_neg;
   logic [3:0]  cnt_inc;
   logic [63:0] v_m1, px_m1, x_sum, y_sum, o_sum;
   logic        d63, ox, oy, oo;
   logic [7:0]  t;
   logic        tz, tm;
   logic [31:0] rem, last_sz, psum_new;
   logic [1:0]  n;
   grp_type     g;

   function automatic logic legacy_z(input logic [7:0] b);
      return b == 8'd9 || b == 8'd10 || b == 8'd11 || b == 8'd13 || b == 8'd15 ||
             b == 8'd18 || b == 8'd19 || b == 8'd20 || b == 8'd31 || b == 8'd32;
   endfunction

   function automatic logic legacy_m(input logic [7:0] b);
      return b == 8'd11 || b == 8'd13 || b == 8'd15 || b == 8'd18 || b == 8'd21 ||
             b == 8'd23 || b == 8'd25 || b == 8'd28 || b == 8'd31;
   endfunction

   function automatic rec_type mk(input logic [2:0] rc, input logic [63:0] a,
                                  input logic [63:0] b, input logic [5:0] k,
                                  input logic [2:0] st, input logic lst);
      rec_type r;
      r.record  = rc;
      r.value_a = a;
      r.value_b = b;
      r.kind    = k[2:0];
      r.z       = k[3];
      r.m       = k[4];
      r.status  = st;
      r.last    = lst;
      return r;
   endfunction

   // Assemble the current varint byte
   always_comb begin
      sgn      = phase_ff >= PH_X;
      first    = cnt_ff == 4'd0;
      more     = byte_in[7];
      cnt_inc  = cnt_ff + 4'd1;
      u_base   = first ? 64'd0 : acc_ff;
      u_sh     = first ? 7'd0 : shift_ff;
      u_val    = u_base | ({57'd0, byte_in[6:0]} << u_sh[5:0]);
      s_mag    = first ? {58'd0, byte_in[5:0]}
                       : acc_ff | ({57'd0, byte_in[6:0]} << shift_ff[5:0]);
      s_neg    = first ? byte_in[6] : neg_ff;
      s_val    = s_neg ? (64'd0 - s_mag) : s_mag;
      hi_bad   = sgn ? (!first && shift_ff >= 7'd62 && byte_in[6:1] != 6'd0)
                     : (u_sh >= 7'd63 && byte_in[6:1] != 6'd0);
      too_long = !hi_bad && more && cnt_inc >= 4'(VarintMaxBytes);
      v_m1     = u_val - 64'd1;
      px_m1    = px_ff - 64'd1;
      d63      = s_neg ? (s_mag != 64'd0) : s_mag[63];
      x_sum    = x_ff + px_ff;
      y_sum    = s_neg ? (y_ff - s_mag) : (y_ff + s_mag);
      o_sum    = s_neg ? (ord_ff - s_mag) : (ord_ff + s_mag);
      ox       = ~(x_ff[63] ^ px_ff[63]) & (x_ff[63] ^ x_sum[63]);
      oy       = ~(y_ff[63] ^ d63) & (y_ff[63] ^ y_sum[63]);
      oo       = ~(ord_ff[63] ^ d63) & (ord_ff[63] ^ o_sum[63]);
      t        = u_val[7:0];
      tz       = (t >= 8'd50) ? u_val[31] : (lz_ff | legacy_z(t));
      tm       = (t >= 8'd50) ? u_val[30] : (lm_ff | legacy_m(t));
      rem      = pt_ff - psum_ff;
      psum_new = psum_ff + u_val[31:0];
   end

   // Parse one byte and build the record group
   always_comb begin
      phase_in = phase_ff;  acc_in = acc_ff;     shift_in = shift_ff;
      cnt_in   = cnt_ff;    neg_in = neg_ff;     kzmc_in  = kzmc_ff;
      pt_in    = pt_ff;     parts_in = parts_ff; psum_in  = psum_ff;
      pleft_in = pleft_ff;  bbox_in = bbox_ff;   x_in     = x_ff;
      y_in     = y_ff;      px_in  = px_ff;      ord_in   = ord_ff;
      fin_in   = fin_ff;    held_in = held_ff;   bad_in   = bad_ff;
      lz_in    = lz_ff;     lm_in  = lm_ff;
      last_sz  = 32'd0;
      n        = 2'd0;
      g        = '0;

      if (csr_we) begin
         if (csr_index == CSR_LAYER_Z) lz_in = csr_wdata;
         else lm_in = csr_wdata;
      end

      if (step && !fin_ff) begin
         if (hi_bad || too_long) begin
            cnt_in = 4'd0;
            fin_in = 1'b1; held_in = ST_INVALID;
         end else if (more) begin
            cnt_in   = cnt_inc;
            neg_in   = s_neg;
            acc_in   = sgn ? s_mag : u_val;
            shift_in = sgn ? (first ? 7'd6 : shift_ff + 7'd7) : u_sh + 7'd7;
         end else begin
            cnt_in = 4'd0;
            unique case (phase_ff)
               PH_TYPE: begin
                  kzmc_in[3] = tz;
                  kzmc_in[4] = tm;
                  kzmc_in[5] = (t == 8'd50 || t == 8'd51) && u_val[29];
                  if (t == 8'd0) begin
                     kzmc_in[2:0] = KIND_POINT; fin_in = 1'b1; held_in = ST_EMPTY;
                  end else if (t == 8'd1 || t == 8'd9 || t == 8'd11 || t == 8'd21 ||
                               t == 8'd52) begin
                     kzmc_in[2:0] = KIND_POINT; phase_in = PH_PT_X;
                  end else if (t == 8'd8 || t == 8'd18 || t == 8'd20 || t == 8'd28 ||
                               t == 8'd53) begin
                     kzmc_in[2:0] = KIND_MPOINT; phase_in = PH_NPOINTS;
                  end else if (t == 8'd3 || t == 8'd10 || t == 8'd13 || t == 8'd23 ||
                               t == 8'd50) begin
                     kzmc_in[2:0] = KIND_MLINE; phase_in = PH_NPOINTS;
                  end else if (t == 8'd5 || t == 8'd15 || t == 8'd19 || t == 8'd25 ||
                               t == 8'd51) begin
                     kzmc_in[2:0] = KIND_MPOLY; phase_in = PH_NPOINTS;
                  end else begin
                     kzmc_in[2:0] = KIND_UNSUPP; fin_in = 1'b1; held_in = ST_TYPE;
                  end
               end
               PH_PT_X: begin
                  px_in = u_val; phase_in = PH_PT_Y;
               end
               PH_PT_Y: begin
                  if (px_ff == 64'd0 || u_val == 64'd0) begin
                     fin_in = 1'b1; held_in = ST_EMPTY;
                  end else if (px_m1[63] || v_m1[63]) begin
                     fin_in = 1'b1; held_in = ST_OVERFLOW;
                  end else begin
                     g.recs[0] = mk(REC_HEADER, 64'd1, 64'd0, kzmc_ff, ST_OK, 1'b0);
                     g.recs[1] = mk(REC_XY, px_m1, v_m1, kzmc_ff, ST_OK, 1'b0);
                     n = 2'd2;
                     if (kzmc_ff[3]) phase_in = PH_PT_Z;
                     else if (kzmc_ff[4]) phase_in = PH_PT_M;
                     else begin fin_in = 1'b1; held_in = ST_OK; end
                  end
               end
               PH_PT_Z, PH_PT_M: begin
                  g.recs[0] = mk((phase_ff == PH_PT_Z) ? REC_Z : REC_M,
                                 (u_val == 64'd0) ? 64'd0 : (v_m1[63] ? I64_MAX : v_m1),
                                 {63'd0, u_val != 64'd0}, kzmc_ff, ST_OK, 1'b0);
                  n = 2'd1;
                  if (phase_ff == PH_PT_Z && kzmc_ff[4]) phase_in = PH_PT_M;
                  else begin fin_in = 1'b1; held_in = ST_OK; end
               end
               PH_NPOINTS: begin
                  if (kzmc_ff[2:0] == KIND_MPOINT) begin
                     if (u_val == 64'd0) begin
                        fin_in = 1'b1; held_in = ST_EMPTY;
                     end else if (u_val[63:32] != 32'd0) begin
                        fin_in = 1'b1; held_in = ST_INVALID;
                     end else begin
                        pt_in = u_val[31:0]; bbox_in = 2'd3; phase_in = PH_BBOX;
                     end
                  end else begin
                     bad_in   = u_val[63:32] != 32'd0;
                     pt_in    = u_val[31:0];
                     phase_in = PH_NPARTS;
                  end
               end
               PH_NPARTS: begin
                  if (pt_ff == 32'd0 && !bad_ff) begin
                     fin_in = 1'b1; held_in = ST_EMPTY;
                  end else begin
                     if (u_val == 64'd0 || u_val[63:32] != 32'd0 || u_val[31:0] > pt_ff)
                        bad_in = 1'b1;
                     parts_in = u_val[31:0];
                     if (kzmc_ff[5]) phase_in = PH_NCURVES;
                     else begin bbox_in = 2'd3; phase_in = PH_BBOX; end
                  end
               end
               PH_NCURVES: begin
                  if (u_val != 64'd0) begin
                     fin_in = 1'b1; held_in = ST_CURVE;
                  end else begin
                     bbox_in = 2'd3; phase_in = PH_BBOX;
                  end
               end
               PH_BBOX: begin
                  if (bbox_ff != 2'd0) begin
                     bbox_in = bbox_ff - 2'd1;
                  end else if (kzmc_ff[2:0] == KIND_MPOINT) begin
                     g.recs[0] = mk(REC_HEADER, {32'd0, pt_ff}, 64'd0, kzmc_ff, ST_OK, 1'b0);
                     g.recs[1] = mk(REC_PART, {32'd0, pt_ff}, 64'd0, kzmc_ff, ST_OK, 1'b0);
                     n = 2'd2;
                     psum_in = 32'd0; pleft_in = pt_ff;
                     x_in = 64'd0; y_in = 64'd0; phase_in = PH_X;
                  end else if (bad_ff) begin
                     fin_in = 1'b1; held_in = ST_INVALID;
                  end else begin
                     g.recs[0] = mk(REC_HEADER, {32'd0, pt_ff}, {32'd0, parts_ff},
                                    kzmc_ff, ST_OK, 1'b0);
                     n = 2'd1;
                     psum_in  = 32'd0;
                     parts_in = parts_ff - 32'd1;
                     if (parts_ff == 32'd1) begin
                        // single part takes all points
                        g.recs[1] = mk(REC_PART, {32'd0, pt_ff}, 64'd0, kzmc_ff, ST_OK, 1'b0);
                        n = 2'd2;
                        pleft_in = pt_ff; x_in = 64'd0; y_in = 64'd0; phase_in = PH_X;
                     end else begin
                        phase_in = PH_PARTS;
                     end
                  end
               end
               PH_PARTS: begin
                  if (u_val == 64'd0 || u_val[63:32] != 32'd0 || u_val[31:0] > rem) begin
                     fin_in = 1'b1; held_in = ST_INVALID;
                  end else begin
                     g.recs[0] = mk(REC_PART, u_val, 64'd0, kzmc_ff, ST_OK, 1'b0);
                     n = 2'd1;
                     psum_in  = psum_new;
                     parts_in = parts_ff - 32'd1;
                     if (parts_ff == 32'd1) begin
                        last_sz = pt_ff - psum_new;
                        if (last_sz == 32'd0) begin
                           fin_in = 1'b1; held_in = ST_INVALID;
                        end else begin
                           g.recs[1] = mk(REC_PART, {32'd0, last_sz}, 64'd0,
                                          kzmc_ff, ST_OK, 1'b0);
                           n = 2'd2;
                           pleft_in = pt_ff; x_in = 64'd0; y_in = 64'd0;
                           phase_in = PH_X;
                        end
                     end
                  end
               end
               PH_X: begin
                  px_in = s_val; phase_in = PH_Y;
               end
               PH_Y: begin
                  if (ox || oy) begin
                     fin_in = 1'b1; held_in = ST_INVALID;
                  end else begin
                     x_in = x_sum; y_in = y_sum;
                     g.recs[0] = mk(REC_XY, x_sum, y_sum, kzmc_ff, ST_OK, 1'b0);
                     n = 2'd1;
                     pleft_in = pleft_ff - 32'd1;
                     if (pleft_ff == 32'd1) begin
                        if (kzmc_ff[3]) begin
                           ord_in = 64'd0; pleft_in = pt_ff; phase_in = PH_Z;
                        end else if (kzmc_ff[4]) begin
                           ord_in = 64'd0; pleft_in = pt_ff; phase_in = PH_M;
                        end else begin
                           fin_in = 1'b1; held_in = ST_OK;
                        end
                     end else begin
                        phase_in = PH_X;
                     end
                  end
               end
               PH_Z, PH_M: begin
                  if (oo) begin
                     fin_in = 1'b1; held_in = ST_INVALID;
                  end else begin
                     ord_in = o_sum;
                     g.recs[0] = mk((phase_ff == PH_Z) ? REC_Z : REC_M, o_sum, 64'd1,
                                    kzmc_ff, ST_OK, 1'b0);
                     n = 2'd1;
                     pleft_in = pleft_ff - 32'd1;
                     if (pleft_ff == 32'd1) begin
                        if (phase_ff == PH_Z && kzmc_ff[4]) begin
                           ord_in = 64'd0; pleft_in = pt_ff; phase_in = PH_M;
                        end else begin
                           fin_in = 1'b1; held_in = ST_OK;
                        end
                     end
                  end
               end
               default: begin
                  fin_in = 1'b1; held_in = ST_INVALID;
               end
            endcase
         end
      end

      // Close the blob: append end status and clear the parse state
      if (step && end_of_blob) begin
         g.recs[n] = mk(REC_END, 64'd0, 64'd0, kzmc_in,
                        fin_in ? held_in : ST_INVALID, 1'b1);
         n = n + 2'd1;
         phase_in = PH_TYPE; acc_in = 64'd0; shift_in = 7'd0; cnt_in = 4'd0;
         neg_in = 1'b0; kzmc_in = 6'd0; pt_in = 32'd0; parts_in = 32'd0;
         psum_in = 32'd0; pleft_in = 32'd0; bbox_in = 2'd0; x_in = 64'd0;
         y_in = 64'd0; px_in = 64'd0; ord_in = 64'd0; fin_in = 1'b0;
         held_in = ST_OK; bad_in = 1'b0;
      end

      g.count   = n;
      grp       = g;
      grp_valid = step && (n != 2'd0);
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE; acc_ff <= 64'd0; shift_ff <= 7'd0; cnt_ff <= 4'd0;
         neg_ff <= 1'b0; kzmc_ff <= 6'd0; pt_ff <= 32'd0; parts_ff <= 32'd0;
         psum_ff <= 32'd0; pleft_ff <= 32'd0; bbox_ff <= 2'd0; x_ff <= 64'd0;
         y_ff <= 64'd0; px_ff <= 64'd0; ord_ff <= 64'd0; fin_ff <= 1'b0;
         held_ff <= ST_OK; bad_ff <= 1'b0; lz_ff <= 1'b0; lm_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; acc_ff <= acc_in; shift_ff <= shift_in; cnt_ff <= cnt_in;
         neg_ff <= neg_in; kzmc_ff <= kzmc_in; pt_ff <= pt_in; parts_ff <= parts_in;
         psum_ff <= psum_in; pleft_ff <= pleft_in; bbox_ff <= bbox_in; x_ff <= x_in;
         y_ff <= y_in; px_ff <= px_in; ord_ff <= ord_in; fin_ff <= fin_in;
         held_ff <= held_in; bad_ff <= bad_in; lz_ff <= lz_in; lm_ff <= lm_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/gbvp_back.sv =====
// Back part: record group queue and one-record-per-beat delivery.
`default_nettype none
module gbvp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire gbvp_pkg::grp_type wr_grp,
   output logic                   full,
   output logic                   empty,
   input  wire logic              pop,
   output gbvp_pkg::rec_type      head
);
   import gbvp_pkg::*;

   grp_type         mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0]      sub_ff, sub_in;
   logic            deq;

   assign full  = cnt_ff == CntW'(QueueDepth);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ptr_ff].recs[sub_ff];

   // Advance within the head group, drop it after its last record
   always_comb begin
      deq       = 1'b0;
      sub_in    = sub_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (pop && !empty) begin
         if (sub_ff == mem_ff[rd_ptr_ff].count - 2'd1) begin
            deq       = 1'b1;
            sub_in    = 2'd0;
            rd_ptr_in = rd_ptr_ff + PtrW'(1);
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
      if (wr_en) wr_ptr_in = wr_ptr_ff + PtrW'(1);
      cnt_in = cnt_ff + CntW'(wr_en) - CntW'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sub_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         sub_ff    <= sub_in;
      end
   end

   // Store incoming groups
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_grp;
   end

endmodule
`default_nettype wire

// ===== rtl/core/geometry_blob_varint_parser.sv =====
// Top level of the geometry blob varint parser.
// Takes one blob byte per clock beat while req_full is low and parses it in the
// same cycle; every byte yields zero to three records (header, part sizes, grid
// points, Z and M values, end status), stored as one group in a four-group queue,
// and handed out one record per beat. Input rate is one byte per cycle and is limited only by
// the queue filling when the result side pops more slowly than records arise.
// The end-status record carries last_result and closes the blob; a nonzero
// status means the records already delivered for that blob are to be dropped.
`default_nettype none
module geometry_blob_varint_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [7:0]         req_byte_in,
   input  wire logic               req_end_of_blob,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [2:0]              rsp_record,
   output logic signed [63:0]      rsp_value_a,
   output logic signed [63:0]      rsp_value_b,
   output logic [2:0]              rsp_geometry_kind,
   output logic                    rsp_carries_z,
   output logic                    rsp_carries_m,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last_result,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic               csr_wdata
);
   import gbvp_pkg::*;

   logic    grp_valid;
   grp_type grp;
   rec_type head;

   gbvp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .step        (req_push && !req_full),
      .byte_in     (req_byte_in),
      .end_of_blob (req_end_of_blob),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .grp_valid   (grp_valid),
      .grp         (grp)
   );

   gbvp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (grp_valid),
      .wr_grp (grp),
      .full   (req_full),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .head   (head)
   );

   // Drive the result beat
   assign rsp_record        = head.record;
   assign rsp_value_a       = $signed(head.value_a);
   assign rsp_value_b       = $signed(head.value_b);
   assign rsp_geometry_kind = head.kind;
   assign rsp_carries_z     = head.z;
   assign rsp_carries_m     = head.m;
   assign rsp_status        = head.status;
   assign rsp_last_result   = head.last;

endmodule
`default_nettype wire

// ===== rtl/core/gbvp_checker.sv =====
// Port-level checks of the geometry blob varint parser and their binding.
`default_nettype none
module gbvp_props (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic [2:0]         rsp_record,
   input wire logic [2:0]         rsp_status,
   input wire logic               rsp_last_result
);
   import gbvp_pkg::*;

   // Status is only reported on the closing record
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_record != REC_END) |-> rsp_status == ST_OK)
      else $error("status set on a non-end record");

   // Last flag marks exactly the end record
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_result == (rsp_record == REC_END)))
      else $error("last flag and end record disagree");

   // Queue starts empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not empty after reset");

   // A full queue always has a record to show
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("full and empty together");

endmodule

bind geometry_blob_varint_parser gbvp_props u_gbvp_props (.*);
`default_nettype wire
